// ===== rtl/ffpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpm_pkg
// Types, field constants and regime helpers for the fixed-field posit multiplier
// ----------------------------------------------------------------------------
package ffpm_pkg;

    localparam int FRAC_BITS = 23;
    localparam int REG_BITS  = 6;
    localparam int EXP_BITS  = 2;
    localparam int CODE_BITS = 1 + REG_BITS + EXP_BITS + FRAC_BITS;
    localparam int SIG_BITS  = FRAC_BITS + 1;
    localparam int PROD_BITS = 2 * SIG_BITS;

    localparam int EXP_LSB = FRAC_BITS;
    localparam int REG_LSB = FRAC_BITS + EXP_BITS;
    localparam int SGN_BIT = CODE_BITS - 1;

    localparam logic signed [4:0] K_MAX = 5'sd5;
    localparam logic signed [4:0] K_MIN = -5'sd6;

    typedef struct packed {
        logic [CODE_BITS-1:0] a_code;
        logic [CODE_BITS-1:0] b_code;
    } t_in;

    typedef struct packed {
        logic [CODE_BITS-1:0] product_code;
        logic                 out_of_range;
    } t_out;

    // run length of the leading bit gives k: ones mean k = run - 1, zeros k = -run
    function automatic logic signed [3:0] decode_k(input logic [REG_BITS-1:0] reg_f);
        logic       lead;
        logic       stop;
        logic [2:0] run;
        logic signed [3:0] k;
        lead = reg_f[REG_BITS-1];
        stop = 1'b0;
        run  = 3'd0;
        for (int i = REG_BITS - 1; i >= 0; i--) begin
            if (!stop && (reg_f[i] == lead)) begin
                run = run + 3'd1;
            end else begin
                stop = 1'b1;
            end
        end
        if (lead) begin
            k = $signed({1'b0, run}) - 4'sd1;
        end else begin
            k = -$signed({1'b0, run});
        end
        return k;
    endfunction

    // k must lie in -6..5
    function automatic logic [REG_BITS-1:0] encode_k(input logic signed [4:0] k);
        logic [2:0]          amt;
        logic [REG_BITS-1:0] reg_f;
        logic signed [4:0]   neg_k;
        neg_k = -k;
        if (k >= 0) begin
            amt   = k[2:0] + 3'd1;
            reg_f = ~({REG_BITS{1'b1}} >> amt);
        end else begin
            amt   = neg_k[2:0];
            reg_f = {1'b1, {(REG_BITS-1){1'b0}}} >> amt;
        end
        return reg_f;
    endfunction

endpackage

// ===== rtl/ffpm_core.sv =====
// ----------------------------------------------------------------------------
// ffpm_core
// Single-pass product datapath: regime/exponent add, significand multiply,
// normalisation and saturation
// ----------------------------------------------------------------------------
module ffpm_core
    import ffpm_pkg::*;
(
    input  t_in  i_op,
    output t_out o_res
);

    logic                  sign;
    logic signed [4:0]     k_sum;
    logic signed [4:0]     k_fin;
    logic [2:0]            e_sum;
    logic [2:0]            e_norm;
    logic [EXP_BITS-1:0]   e_fin;
    logic [SIG_BITS-1:0]   sig_a;
    logic [SIG_BITS-1:0]   sig_b;
    logic [PROD_BITS-1:0]  prod;
    logic [FRAC_BITS-1:0]  frac;
    logic                  over;
    logic                  under;

    assign sign  = i_op.a_code[SGN_BIT] ^ i_op.b_code[SGN_BIT];
    assign k_sum = 5'(decode_k(i_op.a_code[REG_LSB +: REG_BITS]))
                 + 5'(decode_k(i_op.b_code[REG_LSB +: REG_BITS]));
    assign e_sum = {1'b0, i_op.a_code[EXP_LSB +: EXP_BITS]}
                 + {1'b0, i_op.b_code[EXP_LSB +: EXP_BITS]};
    assign sig_a = {1'b1, i_op.a_code[FRAC_BITS-1:0]};
    assign sig_b = {1'b1, i_op.b_code[FRAC_BITS-1:0]};
    assign prod  = sig_a * sig_b;

    // product of 2 or more shifts right once
    always_comb begin
        if (prod[PROD_BITS-1]) begin
            frac   = prod[PROD_BITS-2 -: FRAC_BITS];
            e_norm = e_sum + 3'd1;
        end else begin
            frac   = prod[PROD_BITS-3 -: FRAC_BITS];
            e_norm = e_sum;
        end
    end

    // exponent carry moves into the regime
    always_comb begin
        if (e_norm[2]) begin
            e_fin = e_norm[EXP_BITS-1:0];
            k_fin = k_sum + 5'sd1;
        end else begin
            e_fin = e_norm[EXP_BITS-1:0];
            k_fin = k_sum;
        end
    end

    assign over  = (k_fin > K_MAX);
    assign under = (k_fin < K_MIN);

    always_comb begin
        priority if (over) begin
            o_res.product_code = {sign, encode_k(K_MAX), {EXP_BITS{1'b1}},
                                  {FRAC_BITS{1'b1}}};
            o_res.out_of_range = 1'b1;
        end else if (under) begin
            o_res.product_code = {sign, encode_k(K_MIN), {EXP_BITS{1'b0}},
                                  {FRAC_BITS{1'b0}}};
            o_res.out_of_range = 1'b1;
        end else begin
            o_res.product_code = {sign, encode_k(k_fin), e_fin, frac};
            o_res.out_of_range = 1'b0;
        end
    end

endmodule

// ===== rtl/fixed_field_posit_multiplier.sv =====
// ----------------------------------------------------------------------------
// fixed_field_posit_multiplier
// Multiplies two fixed-field posit codes, when not stalled one product per cycle
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a request of two operand codes
// (i_in_data). Output channel: o_out_valid / i_out_stall carry the product code
// and an out_of_range flag (o_out_data). A request moves when valid is high
// and stall is low.
// Operands are captured in an input register, the 24x24 significand multiply
// plus normalisation runs in one combinational pass, and the result lands in
// the output register.
// Throughput is one request per cycle while the receiver does not stall; the
// single multiplier between the two registers sets that figure.
// When the receiver stalls, the output register holds and the input register
// keeps its request; o_in_stall rises only when both are full, so one new
// request is still taken while a finished result waits.
// Reset (synchronous, active low) empties both registers.
// ----------------------------------------------------------------------------
module fixed_field_posit_multiplier
    import ffpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic r_in_valid;
    logic n_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out_data;
    t_out core_res;
    logic out_load;
    logic in_load;

    ffpm_core u_core (
        .i_op  (r_in_data),
        .o_res (core_res)
    );

    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_load || (r_in_valid && !out_load);
    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_data <= i_in_data;
        end
        if (out_load) begin
            r_out_data <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
